[src/pfde_pkg.sv]
// Shared codes, widths and helper function of the page frame store draw engine.
package pfde_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = 10;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 19;

    localparam logic [2:0] FUNC_PIXEL = 3'd0;
    localparam logic [2:0] FUNC_HLINE = 3'd1;
    localparam logic [2:0] FUNC_VLINE = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    localparam logic [2:0] COLOR_BLACK = 3'd0;
    localparam logic [2:0] COLOR_WHITE = 3'd1;
    localparam logic [2:0] COLOR_GREY  = 3'd2;
    localparam logic [2:0] COLOR_SPARE = 3'd3;
    localparam logic [2:0] COLOR_GHOST = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Remainder by five of a column number, through a reciprocal multiply.
    function automatic logic [2:0] mod5_small(input logic [8:0] v);
        logic [17:0] prod;
        logic [7:0]  q;
        logic [8:0]  r;
        prod = 18'(v) * 18'd205;
        q    = prod[17:10];
        r    = v - 9'(q) * 9'd5;
        return r[2:0];
    endfunction

endpackage

[src/pfde_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/page_framebuffer_draw_engine.sv]
// Top level of the page frame store draw engine: command decode, clipping and RMW sequencer.
// Items are taken one at a time, with the pace set by the single write port of the frame store:
// one byte is read-modify-written per cycle. After reset the store is swept to zero, one byte
// a cycle, while no item is accepted; the rotation register resets to zero.
module page_framebuffer_draw_engine
    import pfde_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command item, from bit 0 up: func[3], x_coord[16], y_coord[16], length[16],
    // color[3], read_address[10].
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    // Result item, from bit 0 up: read_data[8].
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,
    // Rotation register write.
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data
);

    // The position width holds a clipped line end, which may equal the panel size.
    localparam int MAX_DIM  = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
    localparam int POS_W    = $clog2(MAX_DIM + 1);
    localparam int PAGES    = (DISPLAY_HEIGHT + 7) / 8;
    localparam int RAW_AW   = $clog2(DISPLAY_WIDTH * PAGES);
    // One bit above the store index so that bytes beyond the store can be detected.
    localparam int ADDR_W   = (RAW_AW > STORE_AW) ? RAW_AW : STORE_AW + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLIP   = 8'b0000_0010,
        S_PREP   = 8'b0000_0100,
        S_DRAW   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_CLEAR  = 8'b0010_0000,
        S_RDREQ  = 8'b0100_0000,
        S_RDWAIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_rot;

    // Command after rotation, in panel coordinates.
    logic   r_kind_v, n_kind_v;
    t_coord r_x, n_x;
    t_coord r_y, n_y;
    t_coord r_len, n_len;
    logic [2:0] r_color, n_color;
    logic [STORE_AW-1:0] r_raddr, n_raddr;

    // Clipped span along the line and its fixed coordinate across it.
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_end, n_end;
    logic [POS_W-1:0] r_across, n_across;

    // Sequencer position: column for a horizontal line, page for a vertical one.
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_first, n_first;
    logic [POS_W-1:0]  r_last, n_last;
    logic [2:0]        r_mod5, n_mod5;
    logic [ADDR_W-1:0] r_addr, n_addr;

    logic [STORE_AW-1:0] r_clr_cnt, n_clr_cnt;

    // Write half of the read-modify-write, registered to go in the cycle after the read.
    logic                r_wr_pend, n_wr_pend;
    logic [STORE_AW-1:0] r_wr_addr, n_wr_addr;
    logic [BYTE_W-1:0]   r_wr_mask, n_wr_mask;
    logic [BYTE_W-1:0]   r_wr_bits, n_wr_bits;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data, n_out_data;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    // Input fields.
    logic [2:0]  in_func;
    t_coord      in_x, in_y, in_len;
    logic [2:0]  in_color;
    logic [STORE_AW-1:0] in_raddr;
    logic        in_accept;

    assign in_func   = i_s_axis_tdata[2:0];
    assign in_x      = t_coord'($signed(i_s_axis_tdata[18:3]));
    assign in_y      = t_coord'($signed(i_s_axis_tdata[34:19]));
    assign in_len    = t_coord'($signed(i_s_axis_tdata[50:35]));
    assign in_color  = i_s_axis_tdata[53:51];
    assign in_raddr  = i_s_axis_tdata[63:54];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    localparam t_coord WC  = t_coord'(DISPLAY_WIDTH);
    localparam t_coord HC  = t_coord'(DISPLAY_HEIGHT);
    localparam t_coord ONE = t_coord'(1);

    // Clip arithmetic.
    t_coord c_along, c_across, c_alim, c_xlim, c_st, c_en;
    logic   c_ok;

    // Draw-step helpers.
    logic [POS_W-1:0]  endm1;
    logic [2:0]        v_lo, v_hi;
    logic [BYTE_W-1:0] step_mask;
    logic              h_lit;
    logic [ADDR_W-1:0] page_base;

    assign endm1 = r_end - POS_W'(1);

    always_comb begin
        c_along  = r_kind_v ? r_y : r_x;
        c_across = r_kind_v ? r_x : r_y;
        c_alim   = r_kind_v ? HC : WC;
        c_xlim   = r_kind_v ? WC : HC;
        c_st     = (c_along < 0) ? t_coord'(0) : c_along;
        c_en     = c_along + r_len;
        if (c_en > c_alim) begin
            c_en = c_alim;
        end
        c_ok = (c_across >= 0) && (c_across < c_xlim) && (c_en > c_st);
    end

    // Halftone of one horizontal-line pixel at column r_pos on row r_across.
    always_comb begin
        case (r_color)
            COLOR_WHITE: h_lit = 1'b1;
            COLOR_GREY:  h_lit = r_pos[0] ^ r_across[0];
            COLOR_SPARE: h_lit = r_across[0] & ~r_pos[0];
            COLOR_GHOST: begin
                if (r_across[1:0] == 2'd0) begin
                    h_lit = (r_mod5 == 3'd3);
                end else if (r_across[1:0] == 2'd2) begin
                    h_lit = (r_mod5 == 3'd0);
                end else begin
                    h_lit = 1'b0;
                end
            end
            default:     h_lit = 1'b0;
        endcase
    end

    always_comb begin
        v_lo = (r_pos == r_first) ? r_start[2:0] : 3'd0;
        v_hi = (r_pos == r_last) ? endm1[2:0] : 3'd7;
        if (r_kind_v) begin
            step_mask = (8'hFF << v_lo) & (8'hFF >> (3'd7 - v_hi));
        end else begin
            step_mask = 8'b1 << r_across[2:0];
        end
    end

    // Byte offset of the first page a line touches.
    always_comb begin
        if (r_kind_v) begin
            page_base = ADDR_W'(r_start[POS_W-1:3]) * ADDR_W'(DISPLAY_WIDTH);
        end else begin
            page_base = ADDR_W'(r_across[POS_W-1:3]) * ADDR_W'(DISPLAY_WIDTH);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind_v    = r_kind_v;
        n_x         = r_x;
        n_y         = r_y;
        n_len       = r_len;
        n_color     = r_color;
        n_raddr     = r_raddr;
        n_start     = r_start;
        n_end       = r_end;
        n_across    = r_across;
        n_pos       = r_pos;
        n_first     = r_first;
        n_last      = r_last;
        n_mod5      = r_mod5;
        n_addr      = r_addr;
        n_clr_cnt   = r_clr_cnt;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_mask   = r_wr_mask;
        n_wr_bits   = r_wr_bits;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        ram_raddr   = r_raddr;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_color = in_color;
                    n_raddr = in_raddr;
                    n_len   = in_len;
                    // Rotate into panel coordinates; lines may trade direction.
                    case (in_func)
                        FUNC_PIXEL: begin
                            n_kind_v = 1'b1;
                            n_len    = ONE;
                            case (r_rot)
                                2'd1: begin n_x = WC - in_y - ONE; n_y = in_x; end
                                2'd2: begin n_x = WC - in_x - ONE; n_y = HC - in_y - ONE; end
                                2'd3: begin n_x = in_y; n_y = HC - in_x - ONE; end
                                default: begin n_x = in_x; n_y = in_y; end
                            endcase
                            n_state = S_CLIP;
                        end
                        FUNC_HLINE: begin
                            case (r_rot)
                                2'd1: begin
                                    n_kind_v = 1'b1; n_x = WC - in_y - ONE; n_y = in_x;
                                end
                                2'd2: begin
                                    n_kind_v = 1'b0; n_x = WC - in_x - in_len;
                                    n_y = HC - in_y - ONE;
                                end
                                2'd3: begin
                                    n_kind_v = 1'b1; n_x = in_y; n_y = HC - in_x - in_len;
                                end
                                default: begin
                                    n_kind_v = 1'b0; n_x = in_x; n_y = in_y;
                                end
                            endcase
                            n_state = S_CLIP;
                        end
                        FUNC_VLINE: begin
                            case (r_rot)
                                2'd1: begin
                                    n_kind_v = 1'b0; n_x = WC - in_y - in_len; n_y = in_x;
                                end
                                2'd2: begin
                                    n_kind_v = 1'b1; n_x = WC - in_x - ONE;
                                    n_y = HC - in_y - in_len;
                                end
                                2'd3: begin
                                    n_kind_v = 1'b0; n_x = in_y; n_y = HC - in_x - ONE;
                                end
                                default: begin
                                    n_kind_v = 1'b1; n_x = in_x; n_y = in_y;
                                end
                            endcase
                            n_state = S_CLIP;
                        end
                        FUNC_CLEAR: begin
                            n_clr_cnt = '0;
                            n_state   = S_CLEAR;
                        end
                        FUNC_READ: n_state = S_RDREQ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLIP: begin
                n_start  = c_st[POS_W-1:0];
                n_end    = c_en[POS_W-1:0];
                n_across = c_across[POS_W-1:0];
                n_state  = c_ok ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                if (r_kind_v) begin
                    n_pos   = POS_W'(r_start[POS_W-1:3]);
                    n_first = POS_W'(r_start[POS_W-1:3]);
                    n_last  = POS_W'(endm1[POS_W-1:3]);
                    n_addr  = page_base + ADDR_W'(r_across);
                end else begin
                    n_pos   = r_start;
                    n_first = r_start;
                    n_last  = endm1;
                    n_mod5  = mod5_small(9'(r_start));
                    n_addr  = page_base + ADDR_W'(r_start);
                end
                n_state = S_DRAW;
            end
            S_DRAW: begin
                ram_raddr = r_addr[STORE_AW-1:0];
                n_wr_pend = (r_addr < ADDR_W'(STORE_DEPTH));
                n_wr_addr = r_addr[STORE_AW-1:0];
                n_wr_mask = step_mask;
                if (r_kind_v) begin
                    n_wr_bits = (r_color == COLOR_WHITE) ? step_mask : '0;
                    n_addr    = r_addr + ADDR_W'(DISPLAY_WIDTH);
                end else begin
                    n_wr_bits = h_lit ? step_mask : '0;
                    n_addr    = r_addr + ADDR_W'(1);
                end
                n_pos  = r_pos + POS_W'(1);
                n_mod5 = (r_mod5 == 3'd4) ? 3'd0 : r_mod5 + 3'd1;
                if (r_pos == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + STORE_AW'(1);
                if (r_clr_cnt == STORE_AW'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RDREQ: begin
                // Wait until the previous result item has been taken.
                if (!r_out_valid) begin
                    n_state = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = ram_rdata;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else begin
            ram_we    = r_wr_pend;
            ram_waddr = r_wr_addr;
            ram_wdata = (ram_rdata & ~r_wr_mask) | (r_wr_bits & r_wr_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rot       <= 2'd0;
            r_clr_cnt   <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_rot <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind_v   <= n_kind_v;
        r_x        <= n_x;
        r_y        <= n_y;
        r_len      <= n_len;
        r_color    <= n_color;
        r_raddr    <= n_raddr;
        r_start    <= n_start;
        r_end      <= n_end;
        r_across   <= n_across;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_last     <= n_last;
        r_mod5     <= n_mod5;
        r_addr     <= n_addr;
        r_wr_addr  <= n_wr_addr;
        r_wr_mask  <= n_wr_mask;
        r_wr_bits  <= n_wr_bits;
        r_out_data <= n_out_data;
    end

    pfde_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The store is never written while the engine waits for a command.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we) else $error("store written while idle");

    // A result item only appears right after a byte read.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RDWAIT))
        else $error("result item without a read");

    // The write half of a read-modify-write always follows a draw step.
    a_rmw_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(r_state == S_DRAW)) else $error("write without read");

    // The clearing sweep ends after the last byte.
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr_cnt == STORE_AW'(STORE_DEPTH - 1)) |=>
        (r_state == S_IDLE)) else $error("clear sweep did not end");

endmodule
